// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the supervisor RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition implies consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, cons)
`define ASSERT_NEXT(label, clk, rst, cond, cons)
`endif
`endif

// ===== hdl/rlms_pkg.sv =====
// Types, codes and helpers of the remote link motor command supervisor.
// No dependencies; imported by every module of the block.
package rlms_pkg;

   localparam int MAX_REMOTES_DEF = 8;

   localparam logic [15:0] HB_LIMIT_RST   = 16'd100;
   localparam logic [15:0] MOVE_LIMIT_RST = 16'd100;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

   // Command codes.
   typedef enum logic [3:0] {
      OP_TICK        = 4'd0,
      OP_HEARTBEAT   = 4'd1,
      OP_LEFT        = 4'd2,
      OP_RIGHT       = 4'd3,
      OP_TURN_STOP   = 4'd4,
      OP_START       = 4'd5,
      OP_RETREAT     = 4'd6,
      OP_STOP        = 4'd7,
      OP_SPEED       = 4'd8,
      OP_INCH        = 4'd9,
      OP_LINK        = 4'd10,
      OP_CONNECT     = 4'd11,
      OP_CONNECT_ACK = 4'd12
   } op_type;

   // Link status codes.
   localparam logic [1:0] LINK_INIT      = 2'd0;
   localparam logic [1:0] LINK_CONNECTED = 2'd1;
   localparam logic [1:0] LINK_LOST      = 2'd2;

   // Turn direction codes.
   localparam logic [1:0] TURN_NONE  = 2'd0;
   localparam logic [1:0] TURN_LEFT  = 2'd1;
   localparam logic [1:0] TURN_RIGHT = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RUN_ENABLE = 2'd0;
   localparam logic [1:0] CSR_HB_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_MOVE_LIMIT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_APPLY,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [3:0] op;
      logic [7:0] remote_id;
      logic [7:0] payload_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] link_state;
      logic       drive_on;
      logic [2:0] speed_level;
      logic [1:0] turn_state;
      logic       control_mode;
      logic       ack_valid;
      logic [7:0] ack_id;
   } rsp_type;

   typedef struct packed {
      logic        run_enable;
      logic [15:0] heartbeat_limit;
      logic [15:0] move_limit;
   } cfg_type;

   // One row of the remote table.
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] age;
   } entry_type;

   // Increment that sticks at the top of the 16-bit range.
   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
   endfunction

endpackage

// ===== hdl/remote_link_motor_command_supervisor_top.sv =====
// Top level of the remote link motor command supervisor: register port,
// sequencer and remote table. Depends on rlms_pkg, rlms_table and rlms_seq.
//
// One command or tick is in work at a time. A command taken while run_enable
// is 0 goes straight to the finish state. Otherwise an item walks the table
// rows in a read and a check state per row, then passes apply and finish:
// a search stops at the matching row, a tick ages every connected row (or
// stops at the first one past heartbeat_limit) and walks none unless the link
// is connected. The read state comes from the single read port of the remote
// table memory, whose read data is registered. A finished result sits in an
// output register, so the next command is taken while it waits. The table
// needs no clearing after reset: only rows below the fill count are ever read.
module remote_link_motor_command_supervisor_top
   import rlms_pkg::*;
#(
   parameter int MAX_REMOTES = MAX_REMOTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W = (MAX_REMOTES > 1) ? $clog2(MAX_REMOTES) : 1;

   logic             run_ff, run_in;
   logic [15:0]      hb_limit_ff, hb_limit_in;
   logic [15:0]      move_limit_ff, move_limit_in;
   logic             csr_write;
   cfg_type          cfg;
   logic             tbl_rd_en;
   logic [IDX_W-1:0] tbl_rd_addr;
   entry_type        tbl_rd_data;
   logic             tbl_wr_en;
   logic [IDX_W-1:0] tbl_wr_addr;
   entry_type        tbl_wr_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         hb_limit_ff   <= HB_LIMIT_RST;
         move_limit_ff <= MOVE_LIMIT_RST;
      end else begin
         run_ff        <= run_in;
         hb_limit_ff   <= hb_limit_in;
         move_limit_ff <= move_limit_in;
      end
   end

   // Write decode.
   always_comb begin
      run_in        = run_ff;
      hb_limit_in   = hb_limit_ff;
      move_limit_in = move_limit_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            CSR_RUN_ENABLE: run_in        = pwdata[0];
            CSR_HB_LIMIT:   hb_limit_in   = pwdata[15:0];
            CSR_MOVE_LIMIT: move_limit_in = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Read mux.
   always_comb begin
      unique case (paddr[3:2])
         CSR_RUN_ENABLE: prdata = {31'd0, run_ff};
         CSR_HB_LIMIT:   prdata = {16'd0, hb_limit_ff};
         CSR_MOVE_LIMIT: prdata = {16'd0, move_limit_ff};
         default:        prdata = 32'd0;
      endcase
   end

   assign cfg = '{run_enable: run_ff, heartbeat_limit: hb_limit_ff,
                  move_limit: move_limit_ff};

   rlms_seq #(
      .MAX_REMOTES (MAX_REMOTES),
      .IDX_W       (IDX_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .tbl_rd_en   (tbl_rd_en),
      .tbl_rd_addr (tbl_rd_addr),
      .tbl_rd_data (tbl_rd_data),
      .tbl_wr_en   (tbl_wr_en),
      .tbl_wr_addr (tbl_wr_addr),
      .tbl_wr_data (tbl_wr_data)
   );

   rlms_table #(
      .MAX_REMOTES (MAX_REMOTES),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data)
   );

endmodule

// ===== hdl/rlms_table.sv =====
// Remote table memory: one write port, one read port, registered read data.
// Depends on rlms_pkg for the row type.
module rlms_table
   import rlms_pkg::*;
#(
   parameter int MAX_REMOTES = MAX_REMOTES_DEF,
   parameter int IDX_W       = (MAX_REMOTES > 1) ? $clog2(MAX_REMOTES) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data
);

   entry_type mem [MAX_REMOTES];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rlms_seq.sv =====
// Command sequencer: walks the remote table, applies commands and ticks,
// holds the motor and link state and the result register.
// Depends on rlms_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rlms_seq
   import rlms_pkg::*;
#(
   parameter int MAX_REMOTES = MAX_REMOTES_DEF,
   parameter int IDX_W       = (MAX_REMOTES > 1) ? $clog2(MAX_REMOTES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   output logic             tbl_rd_en,
   output logic [IDX_W-1:0] tbl_rd_addr,
   input  entry_type        tbl_rd_data,
   output logic             tbl_wr_en,
   output logic [IDX_W-1:0] tbl_wr_addr,
   output entry_type        tbl_wr_data
);

   localparam int CNT_W = $clog2(MAX_REMOTES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_REMOTES);

   seq_state_type    state_ff, state_in;
   logic [3:0]       op_ff, op_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       pay_ff, pay_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       link_ff, link_in;
   logic [15:0]      dtimer_ff, dtimer_in;
   logic [15:0]      ttimer_ff, ttimer_in;
   logic             running_ff, running_in;
   logic [2:0]       speed_ff, speed_in;
   logic [1:0]       turn_ff, turn_in;
   logic             mode_ff, mode_in;
   logic             ack_ff, ack_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         link_ff      <= LINK_INIT;
         dtimer_ff    <= '0;
         ttimer_ff    <= '0;
         running_ff   <= 1'b0;
         speed_ff     <= '0;
         turn_ff      <= TURN_NONE;
         mode_ff      <= 1'b0;
         ack_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         link_ff      <= link_in;
         dtimer_ff    <= dtimer_in;
         ttimer_ff    <= ttimer_in;
         running_ff   <= running_in;
         speed_ff     <= speed_in;
         turn_ff      <= turn_in;
         mode_ff      <= mode_in;
         ack_ff       <= ack_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and walk registers.
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      id_ff    <= id_in;
      pay_ff   <= pay_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      slot_ff  <= slot_in;
      rsp_ff   <= rsp_in;
   end

   // Next state, table accesses and command effects.
   always_comb begin
      logic [15:0]      new_age;
      logic [CNT_W-1:0] idx_nxt;
      logic             last;
      logic             refresh;
      logic [1:0]       want;

      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      pay_in       = pay_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      link_in      = link_ff;
      dtimer_in    = dtimer_ff;
      ttimer_in    = ttimer_ff;
      running_in   = running_ff;
      speed_in     = speed_ff;
      turn_in      = turn_ff;
      mode_in      = mode_ff;
      ack_in       = ack_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tbl_rd_en    = 1'b0;
      tbl_rd_addr  = idx_ff[IDX_W-1:0];
      tbl_wr_en    = 1'b0;
      tbl_wr_addr  = idx_ff[IDX_W-1:0];
      tbl_wr_data  = tbl_rd_data;
      new_age      = sat_inc(tbl_rd_data.age);
      idx_nxt      = idx_ff + CNT_W'(1);
      last         = (idx_nxt == count_ff);
      refresh      = 1'b0;
      want         = (op_ff == OP_LEFT) ? TURN_LEFT : TURN_RIGHT;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_data.op;
               id_in    = req_data.remote_id;
               pay_in   = req_data.payload_byte;
               idx_in   = '0;
               found_in = 1'b0;
               ack_in   = 1'b0;
               if (!cfg.run_enable) begin
                  state_in = ST_FINISH;
               end else if (req_data.op == OP_TICK) begin
                  state_in = (link_ff == LINK_CONNECTED && count_ff != '0) ?
                             ST_READ : ST_APPLY;
               end else begin
                  state_in = (count_ff != '0) ? ST_READ : ST_APPLY;
               end
            end
         end
         ST_READ: begin
            tbl_rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (op_ff == OP_TICK) begin
               // Age this entry; the first one past the limit drops the link.
               tbl_wr_en       = 1'b1;
               tbl_wr_data.age = new_age;
               idx_in          = idx_nxt;
               if (new_age > cfg.heartbeat_limit) begin
                  link_in  = LINK_LOST;
                  state_in = ST_APPLY;
               end else begin
                  state_in = last ? ST_APPLY : ST_READ;
               end
            end else if (tbl_rd_data.id == id_ff) begin
               found_in = 1'b1;
               slot_in  = idx_ff[IDX_W-1:0];
               state_in = ST_APPLY;
            end else begin
               idx_in   = idx_nxt;
               state_in = last ? ST_APPLY : ST_READ;
            end
         end
         ST_APPLY: begin
            case (op_ff) inside
               OP_TICK: begin
                  if (dtimer_in != '0) dtimer_in = sat_inc(dtimer_in);
                  if (ttimer_in != '0) ttimer_in = sat_inc(ttimer_in);
               end
               OP_HEARTBEAT: begin
                  refresh = found_ff;
               end
               OP_LEFT, OP_RIGHT: begin
                  if (found_ff) begin
                     refresh = 1'b1;
                     if (turn_ff == want) begin
                        ttimer_in = 16'd1;
                     end else if (turn_ff == TURN_NONE) begin
                        turn_in   = want;
                        ttimer_in = 16'd1;
                     end
                  end
               end
               OP_TURN_STOP: begin
                  if (found_ff) begin
                     refresh   = 1'b1;
                     turn_in   = TURN_NONE;
                     ttimer_in = '0;
                  end
               end
               OP_START: begin
                  if (found_ff) begin
                     if (!running_ff) begin
                        if (pay_ff <= 8'd7) speed_in = pay_ff[2:0];
                        running_in = 1'b1;
                     end
                     dtimer_in = 16'd1;
                  end
               end
               OP_STOP: begin
                  if (found_ff) begin
                     dtimer_in  = '0;
                     running_in = 1'b0;
                  end
               end
               OP_SPEED: begin
                  if (found_ff && pay_ff <= 8'd7) speed_in = pay_ff[2:0];
               end
               OP_INCH, OP_LINK: begin
                  if (found_ff) begin
                     refresh   = 1'b1;
                     mode_in   = (op_ff == OP_LINK);
                     dtimer_in = '0;
                  end
               end
               OP_CONNECT: begin
                  // A new remote takes the next free row.
                  if (!found_ff && count_ff < CNT_FULL) begin
                     tbl_wr_en   = 1'b1;
                     tbl_wr_addr = count_ff[IDX_W-1:0];
                     tbl_wr_data = '{id: id_ff, age: 16'd1};
                     count_in    = count_ff + CNT_W'(1);
                     ack_in      = 1'b1;
                     link_in     = LINK_CONNECTED;
                  end
               end
               default: begin
               end
            endcase
            if (refresh) begin
               tbl_wr_en   = 1'b1;
               tbl_wr_addr = slot_ff;
               tbl_wr_data = '{id: id_ff, age: 16'd1};
            end
            // Motor watchdogs.
            if (dtimer_in > cfg.move_limit) begin
               running_in = 1'b0;
               dtimer_in  = '0;
            end
            if (ttimer_in > cfg.move_limit) begin
               turn_in   = TURN_NONE;
               ttimer_in = '0;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.link_state   = link_ff;
               rsp_in.drive_on     = running_ff;
               rsp_in.speed_level  = speed_ff;
               rsp_in.turn_state   = turn_ff;
               rsp_in.control_mode = mode_ff;
               rsp_in.ack_valid    = ack_ff;
               rsp_in.ack_id       = ack_ff ? id_ff : 8'd0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL)
   `ASSERT_IMPLIES(a_check_in_range, clock, reset, state_ff == ST_CHECK, idx_ff < count_ff)
   `ASSERT_IMPLIES(a_write_phase, clock, reset, tbl_wr_en, state_ff == ST_CHECK || state_ff == ST_APPLY)
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != ST_IDLE)
   `ASSERT_IMPLIES(a_ack_connected, clock, reset, ack_ff, link_ff == LINK_CONNECTED)

endmodule

// ===== test/motor_status_checker.sv =====
// Passive checker for the remote link motor command supervisor: it follows the
// register, command and status channels, predicts each status and compares.
// Depends on rlms_pkg for the transfer types and the command and status codes.
module motor_status_checker
   import rlms_pkg::*;
#(
   parameter int MAX_REMOTES = MAX_REMOTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 40;

   // Register copy.
   logic        run_on;
   logic [15:0] hb_limit;
   logic [15:0] move_limit;

   // Supervisor state as the checker sees it.
   logic [7:0]  table_ids  [MAX_REMOTES];
   logic [15:0] table_ages [MAX_REMOTES];
   int          table_fill;
   logic [1:0]  link;
   logic [15:0] drive_tmr;
   logic [15:0] turn_tmr;
   logic        drive_on;
   logic [2:0]  speed_now;
   logic [1:0]  turn_dir;
   logic        mode;

   rsp_type expected_status_q [$];
   int      status_seen;

   // Counter step that holds at the top of the 16-bit range.
   function automatic logic [15:0] bump16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   // Applies one command to the state copy and returns the status it yields.
   function automatic rsp_type predict_motor_status(input req_type item);
      rsp_type    r;
      logic       known;
      int         slot;
      logic [1:0] want;
      r = '0;
      known = 1'b0;
      slot = 0;
      for (int i = 0; i < table_fill; i++) begin
         if (!known && table_ids[i] == item.remote_id) begin
            known = 1'b1;
            slot = i;
         end
      end
      if (run_on) begin
         case (item.op) inside
            OP_TICK: begin
               // Heartbeats age in table order until the first one runs out.
               if (link == LINK_CONNECTED) begin
                  for (int i = 0; i < table_fill; i++) begin
                     if (link == LINK_CONNECTED) begin
                        table_ages[i] = bump16(table_ages[i]);
                        if (table_ages[i] > hb_limit) link = LINK_LOST;
                     end
                  end
               end
               if (drive_tmr != 16'd0) drive_tmr = bump16(drive_tmr);
               if (turn_tmr != 16'd0) turn_tmr = bump16(turn_tmr);
            end
            OP_HEARTBEAT: begin
               if (known) table_ages[slot] = 16'd1;
            end
            OP_LEFT, OP_RIGHT: begin
               if (known) begin
                  want = (item.op == OP_LEFT) ? TURN_LEFT : TURN_RIGHT;
                  // A turn the other way is refused but still counts as a heartbeat.
                  if (turn_dir == want) begin
                     turn_tmr = 16'd1;
                  end else if (turn_dir == TURN_NONE) begin
                     turn_dir = want;
                     turn_tmr = 16'd1;
                  end
                  table_ages[slot] = 16'd1;
               end
            end
            OP_TURN_STOP: begin
               if (known) begin
                  turn_dir = TURN_NONE;
                  turn_tmr = 16'd0;
                  table_ages[slot] = 16'd1;
               end
            end
            OP_START: begin
               if (known) begin
                  // A running drive keeps its speed; only the timer restarts.
                  if (!drive_on) begin
                     if (item.payload_byte <= 8'd7) speed_now = item.payload_byte[2:0];
                     drive_on = 1'b1;
                  end
                  drive_tmr = 16'd1;
               end
            end
            OP_STOP: begin
               if (known) begin
                  drive_tmr = 16'd0;
                  drive_on = 1'b0;
               end
            end
            OP_SPEED: begin
               if (known && item.payload_byte <= 8'd7) speed_now = item.payload_byte[2:0];
            end
            OP_INCH, OP_LINK: begin
               if (known) begin
                  mode = (item.op == OP_LINK);
                  drive_tmr = 16'd0;
                  table_ages[slot] = 16'd1;
               end
            end
            OP_CONNECT: begin
               if (!known && table_fill < MAX_REMOTES) begin
                  table_ids[table_fill] = item.remote_id;
                  table_ages[table_fill] = 16'd1;
                  table_fill++;
                  r.ack_valid = 1'b1;
                  r.ack_id = item.remote_id;
                  link = LINK_CONNECTED;
               end
            end
            default: begin
            end
         endcase

         // Motors whose timer ran past the limit are stopped.
         if (drive_tmr > move_limit) begin
            drive_on = 1'b0;
            drive_tmr = 16'd0;
         end
         if (turn_tmr > move_limit) begin
            turn_dir = TURN_NONE;
            turn_tmr = 16'd0;
         end
      end
      r.link_state = link;
      r.drive_on = drive_on;
      r.speed_level = speed_now;
      r.turn_state = turn_dir;
      r.control_mode = mode;
      return r;
   endfunction

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("[%0t] status %0d: %s is 0x%0h, expected 0x%0h",
                  $time, status_seen, field, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         run_on = 1'b0;
         hb_limit = HB_LIMIT_RST;
         move_limit = MOVE_LIMIT_RST;
         table_fill = 0;
         link = LINK_INIT;
         drive_tmr = 16'd0;
         turn_tmr = 16'd0;
         drive_on = 1'b0;
         speed_now = 3'd0;
         turn_dir = TURN_NONE;
         mode = 1'b0;
         expected_status_q.delete();
         status_seen = 0;
         fail_count = 0;
      end else begin
         // Register writes.
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               CSR_RUN_ENABLE: run_on = pwdata[0];
               CSR_HB_LIMIT:   hb_limit = pwdata[15:0];
               CSR_MOVE_LIMIT: move_limit = pwdata[15:0];
               default: begin
               end
            endcase
         end

         // Status transfers are compared with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_status_q.size() == 0) begin
               report_mismatch("unexpected transfer", 32'(rsp_data), 32'd0);
            end else begin
               want = expected_status_q.pop_front();
               if (rsp_data.link_state !== want.link_state)
                  report_mismatch("link_state", 32'(rsp_data.link_state), 32'(want.link_state));
               if (rsp_data.drive_on !== want.drive_on)
                  report_mismatch("drive_on", 32'(rsp_data.drive_on), 32'(want.drive_on));
               if (rsp_data.speed_level !== want.speed_level)
                  report_mismatch("speed_level", 32'(rsp_data.speed_level),
                                  32'(want.speed_level));
               if (rsp_data.turn_state !== want.turn_state)
                  report_mismatch("turn_state", 32'(rsp_data.turn_state), 32'(want.turn_state));
               if (rsp_data.control_mode !== want.control_mode)
                  report_mismatch("control_mode", 32'(rsp_data.control_mode),
                                  32'(want.control_mode));
               if (rsp_data.ack_valid !== want.ack_valid)
                  report_mismatch("ack_valid", 32'(rsp_data.ack_valid), 32'(want.ack_valid));
               if (rsp_data.ack_id !== want.ack_id)
                  report_mismatch("ack_id", 32'(rsp_data.ack_id), 32'(want.ack_id));
            end
            status_seen++;
         end

         // Each command transfer yields exactly one status.
         if (req_valid && !req_stall)
            expected_status_q.push_back(predict_motor_status(req_data));
      end
      pending_count = expected_status_q.size();
   end

endmodule

// ===== test/testbench.sv =====
// Top of the supervisor testbench: clock, reset, register writes, command and
// status stimulus with random idling, and the verdict.
// Depends on rlms_pkg, the supervisor RTL and motor_status_checker.
module testbench
   import rlms_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int END_WAIT    = 40;
   localparam logic [3:0] OP_UNUSED_15 = 4'd15;
   localparam logic [7:0] ID_POOL [10] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h0F,
                                           8'hF0, 8'h33, 8'hCC, 8'h96, 8'h69};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int   fail_count;
   int   pending_count;
   int   idle_cycles = 0;
   logic quiet = 1'b0;

   remote_link_motor_command_supervisor_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   motor_status_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Status stall in random bursts, switched off in the quiet part.
   initial begin : status_stall
      int   burst_len;
      logic hold;
      forever begin
         burst_len = $urandom_range(1, 16);
         hold = ($urandom_range(0, 2) == 0);
         repeat (burst_len) begin
            @(negedge clock);
            rsp_stall <= hold && !quiet;
         end
      end
   end

   function automatic req_type cmd(input logic [3:0] op, input logic [7:0] id,
                                   input logic [7:0] pay);
      req_type item;
      item.op = op;
      item.remote_id = id;
      item.payload_byte = pay;
      return item;
   endfunction

   // Mostly commands from a small set of ids so that the table is hit,
   // mixed with stray ids, odd op codes and out-of-range speed codes.
   function automatic req_type random_command();
      req_type item;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)      item.op = OP_TICK;
      else if (pick < 35) item.op = OP_HEARTBEAT;
      else if (pick < 50) item.op = 4'($urandom_range(OP_LEFT, OP_TURN_STOP));
      else if (pick < 62) item.op = ($urandom_range(0, 1) == 0) ? OP_START : OP_STOP;
      else if (pick < 72) item.op = OP_SPEED;
      else if (pick < 80) item.op = ($urandom_range(0, 1) == 0) ? OP_INCH : OP_LINK;
      else if (pick < 86) item.op = OP_CONNECT;
      else if (pick < 93) item.op = 4'($urandom_range(OP_CONNECT_ACK, OP_UNUSED_15));
      else                item.op = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 82) item.remote_id = ID_POOL[$urandom_range(0, 9)];
      else                            item.remote_id = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 60) item.payload_byte = 8'($urandom_range(0, 7));
      else                            item.payload_byte = 8'($urandom_range(0, 255));
      return item;
   endfunction

   // One command transfer, sometimes after a random gap.
   task automatic send_command(input req_type item);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Setup and access cycle of one register write.
   task automatic write_register(input logic [1:0] index, input logic [15:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {16'h0000, value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Stops sending and waits until every predicted status has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      logic        run_set;
      logic [15:0] hb_set;
      logic [15:0] move_set;
      int          n_items;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Run disabled after reset: everything is ignored.
      send_command(cmd(OP_CONNECT, 8'h3C, 8'h00));
      send_command(cmd(OP_START, 8'h3C, 8'h05));
      send_command(cmd(OP_TICK, 8'h3C, 8'h00));
      wait_for_drain();

      write_register(CSR_RUN_ENABLE, 16'd1);
      write_register(CSR_HB_LIMIT, 16'd3);
      write_register(CSR_MOVE_LIMIT, 16'd2);

      // Directed part: table handling, drive and turn rules, timeouts, link loss.
      send_command(cmd(OP_HEARTBEAT, 8'h11, 8'h00));
      send_command(cmd(OP_CONNECT, 8'h00, 8'h00));
      send_command(cmd(OP_CONNECT, 8'h00, 8'h00));
      send_command(cmd(OP_CONNECT, 8'hFF, 8'hFF));
      send_command(cmd(OP_START, 8'hFF, 8'h05));
      send_command(cmd(OP_START, 8'hFF, 8'h03));
      send_command(cmd(OP_SPEED, 8'hFF, 8'hFF));
      send_command(cmd(OP_SPEED, 8'h00, 8'h07));
      send_command(cmd(OP_LEFT, 8'h00, 8'h00));
      send_command(cmd(OP_RIGHT, 8'h00, 8'h00));
      send_command(cmd(OP_TICK, 8'h00, 8'h00));
      send_command(cmd(OP_TICK, 8'hFF, 8'h00));
      send_command(cmd(OP_TICK, 8'h00, 8'h00));
      send_command(cmd(OP_RETREAT, 8'h00, 8'h02));
      send_command(cmd(OP_CONNECT_ACK, 8'h00, 8'h00));
      send_command(cmd(OP_UNUSED_15, 8'hFF, 8'h01));
      send_command(cmd(OP_CONNECT, 8'hA5, 8'h00));
      send_command(cmd(OP_START, 8'hA5, 8'h06));
      send_command(cmd(OP_LINK, 8'hA5, 8'h00));
      send_command(cmd(OP_INCH, 8'hFF, 8'h00));
      send_command(cmd(OP_RIGHT, 8'hFF, 8'h00));
      send_command(cmd(OP_TURN_STOP, 8'hFF, 8'h00));
      send_command(cmd(OP_START, 8'h5A, 8'h04));
      send_command(cmd(OP_STOP, 8'h00, 8'h00));
      send_command(cmd(OP_SPEED, 8'h00, 8'h00));
      wait_for_drain();

      // Random phases over several register settings, extremes included.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       begin run_set = 1'b1; hb_set = 16'd65534; move_set = 16'd1;     end
            1:       begin run_set = 1'b1; hb_set = 16'd12;    move_set = 16'd6;     end
            2:       begin run_set = 1'b0; hb_set = 16'd12;    move_set = 16'd6;     end
            3:       begin run_set = 1'b1; hb_set = 16'd1;     move_set = 16'd65534; end
            default: begin run_set = 1'b1; hb_set = 16'd40;    move_set = 16'd20;    end
         endcase
         n_items = run_set ? 130 : 30;
         write_register(CSR_RUN_ENABLE, {15'd0, run_set});
         write_register(CSR_HB_LIMIT, hb_set);
         write_register(CSR_MOVE_LIMIT, move_set);
         repeat (n_items) send_command(random_command());
         wait_for_drain();
      end

      // Quiet part: drive and turn timers run past the move limit.
      quiet = 1'b1;
      write_register(CSR_RUN_ENABLE, 16'd1);
      write_register(CSR_HB_LIMIT, 16'd1);
      write_register(CSR_MOVE_LIMIT, 16'd40);
      send_command(cmd(OP_STOP, 8'h00, 8'h00));
      send_command(cmd(OP_TURN_STOP, 8'h00, 8'h00));
      send_command(cmd(OP_START, 8'h00, 8'h03));
      send_command(cmd(OP_LEFT, 8'hFF, 8'h00));
      repeat (60)
         send_command(cmd(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
      send_command(cmd(OP_SPEED, 8'hA5, 8'h02));
      wait_for_drain();

      repeat (END_WAIT) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== remote_link_motor_command_supervisor_top.f =====
+incdir+hdl
hdl/rlms_pkg.sv
hdl/rlms_table.sv
hdl/rlms_seq.sv
hdl/remote_link_motor_command_supervisor_top.sv
test/motor_status_checker.sv
test/testbench.sv
